>>> src/protected_range_table_macros.svh
// ----------------------------------------------------------------------------
// Protected range table assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PROTECTED_RANGE_TABLE_MACROS_SVH
`define PROTECTED_RANGE_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PRT_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define PRT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/prt_pkg.sv
// ----------------------------------------------------------------------------
// Protected range table package
// Result codes, command codes and the entry compare result type.
// ----------------------------------------------------------------------------
package prt_pkg;

    localparam int ADDR_W = 32;
    localparam int LEN_W  = 33;

    localparam logic CMD_QUERY   = 1'b0;
    localparam logic CMD_PROTECT = 1'b1;

    localparam logic [1:0] COV_NONE    = 2'd0;
    localparam logic [1:0] COV_FULL    = 2'd1;
    localparam logic [1:0] COV_PARTIAL = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_REFUSED = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    // Relation of one table entry to the span under test.
    typedef struct packed {
        logic full;       // entry holds the whole span
        logic part;       // entry overlaps the span in part
        logic adj_front;  // span ends where the entry starts
        logic adj_back;   // entry ends where the span starts
    } cmp_t;

endpackage

>>> src/prt_span_cmp.sv
// ----------------------------------------------------------------------------
// Protected range table entry comparator
// Relates one stored region to the current span with 33-bit compares.
// ----------------------------------------------------------------------------
module prt_span_cmp
(
    input  logic [prt_pkg::ADDR_W-1:0] ent_start,
    input  logic [prt_pkg::LEN_W-1:0]  ent_end,
    input  logic [prt_pkg::ADDR_W-1:0] span_pos,
    input  logic [prt_pkg::LEN_W-1:0]  span_end,
    output prt_pkg::cmp_t              res
);

    logic [prt_pkg::LEN_W-1:0] s_ext;
    logic [prt_pkg::LEN_W-1:0] p_ext;
    logic                      s_le_p;

    always_comb
    begin
        s_ext  = {1'b0, ent_start};
        p_ext  = {1'b0, span_pos};
        s_le_p = (s_ext <= p_ext);

        res.full      = s_le_p && (ent_end >= span_end);
        res.part      = ((s_ext >= p_ext) && (s_ext < span_end)) ||
                        (s_le_p && (ent_end > p_ext));
        res.adj_front = (span_end == s_ext);
        res.adj_back  = (ent_end == p_ext);
    end

endmodule

>>> src/protected_range_table.sv
// Throughput: one transaction at a time; the scan reads one table entry per cycle
// through the single read port of the region memory, so entry_count sets the rate.
// Reset: asynchronous, active low; the table is empty afterwards and the region
// memory itself is not cleared, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
// Protected range table
// Keeps protected address regions in insertion order, answers coverage
// queries and adds regions, joining and merging adjoining ones.
// ----------------------------------------------------------------------------
`include "protected_range_table_macros.svh"

module protected_range_table
#(
    parameter int TABLE_DEPTH    = 16,
    parameter int MIN_REGION_LEN = 8
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // start_addr [31:0], span_len [63:32]
    input  logic        s_axis_tuser,   // cmd [0]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // coverage [1:0], status [3:2], zero [7:4]
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int AW    = prt_pkg::ADDR_W;
    localparam int LW    = prt_pkg::LEN_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SUM,
        ST_SUM_NEXT,
        ST_WRITE,
        ST_SHIFT,
        ST_RESP
    } state_t;

    // Region memory, one write and one registered read port.
    logic [AW-1:0] mem_start [TABLE_DEPTH];
    logic [LW-1:0] mem_len   [TABLE_DEPTH];

    state_t        state_reg;
    logic [CNT_W-1:0] count_reg;
    logic          cmd_reg;
    logic [AW-1:0] pos_reg;
    logic [31:0]   len_reg;
    logic [LW-1:0] span_end_reg;
    logic [1:0]    cov_reg;
    logic [1:0]    status_reg;

    logic [CNT_W-1:0] iss_reg;
    logic          v1_reg;
    logic [CNT_W-1:0] i1_reg;
    logic [AW-1:0] rd_start_reg;
    logic [LW-1:0] rd_len_reg;
    logic          v2_reg;
    logic [CNT_W-1:0] i2_reg;
    logic [AW-1:0] s2_reg;
    logic [LW-1:0] l2_reg;
    logic [LW-1:0] e2_reg;

    logic          adj_found_reg;
    logic [CNT_W-1:0] adj_k_reg;
    logic          adj_front_reg;
    logic [AW-1:0] adj_s_reg;
    logic [LW-1:0] adj_l_reg;
    logic          nxt_match_reg;
    logic [LW-1:0] nxt_l_reg;
    logic [LW-1:0] sum_reg;

    logic          m_valid_reg;
    logic [1:0]    m_cov_reg;
    logic [1:0]    m_status_reg;

    prt_pkg::cmp_t cmp;
    logic          issue;
    logic [IDX_W-1:0] rd_addr;
    logic          wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [AW-1:0] wr_start;
    logic [LW-1:0] wr_len;
    logic          table_full;
    logic          is_short;
    logic [CNT_W-1:0] k_plus1;

    prt_span_cmp u_cmp
    (
        .ent_start (s2_reg),
        .ent_end   (e2_reg),
        .span_pos  (pos_reg),
        .span_end  (span_end_reg),
        .res       (cmp)
    );

    always_comb
    begin
        issue      = ((state_reg == ST_SCAN) || (state_reg == ST_SHIFT)) &&
                     (iss_reg < count_reg);
        rd_addr    = iss_reg[IDX_W-1:0];
        table_full = (count_reg == CNT_W'(TABLE_DEPTH));
        is_short   = (len_reg < 32'(MIN_REGION_LEN));
        k_plus1    = CNT_W'(adj_k_reg + CNT_W'(1));

        wr_en    = 1'b0;
        wr_addr  = count_reg[IDX_W-1:0];
        wr_start = pos_reg;
        wr_len   = {1'b0, len_reg};
        unique case (state_reg)
            ST_DECIDE:
            begin
                wr_en = (cmd_reg == prt_pkg::CMD_PROTECT) && !is_short &&
                        (cov_reg == prt_pkg::COV_NONE) && !adj_found_reg && !table_full;
            end
            ST_WRITE:
            begin
                wr_en    = 1'b1;
                wr_addr  = adj_k_reg[IDX_W-1:0];
                wr_start = adj_front_reg ? pos_reg : adj_s_reg;
                wr_len   = sum_reg;
            end
            ST_SHIFT:
            begin
                wr_en    = v1_reg;
                wr_addr  = IDX_W'(i1_reg - CNT_W'(1));
                wr_start = rd_start_reg;
                wr_len   = rd_len_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_start[wr_addr] <= wr_start;
            mem_len[wr_addr]   <= wr_len;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_start_reg <= mem_start[rd_addr];
        rd_len_reg   <= mem_len[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmd_reg       <= prt_pkg::CMD_QUERY;
            pos_reg       <= '0;
            len_reg       <= '0;
            span_end_reg  <= '0;
            cov_reg       <= prt_pkg::COV_NONE;
            status_reg    <= prt_pkg::STATUS_OK;
            iss_reg       <= '0;
            v1_reg        <= 1'b0;
            i1_reg        <= '0;
            v2_reg        <= 1'b0;
            i2_reg        <= '0;
            s2_reg        <= '0;
            l2_reg        <= '0;
            e2_reg        <= '0;
            adj_found_reg <= 1'b0;
            adj_k_reg     <= '0;
            adj_front_reg <= 1'b0;
            adj_s_reg     <= '0;
            adj_l_reg     <= '0;
            nxt_match_reg <= 1'b0;
            nxt_l_reg     <= '0;
            sum_reg       <= '0;
            m_valid_reg   <= 1'b0;
            m_cov_reg     <= prt_pkg::COV_NONE;
            m_status_reg  <= prt_pkg::STATUS_OK;
        end
        else
        begin
            // In ST_RESP the result register is handled by the state itself.
            if (m_valid_reg && m_axis_tready && (state_reg != ST_RESP))
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        cmd_reg       <= s_axis_tuser;
                        pos_reg       <= s_axis_tdata[31:0];
                        len_reg       <= s_axis_tdata[63:32];
                        // A zero length is taken as one byte for the coverage check.
                        span_end_reg  <= {1'b0, s_axis_tdata[31:0]} +
                                         ((s_axis_tdata[63:32] == 32'd0) ?
                                          LW'(1) : {1'b0, s_axis_tdata[63:32]});
                        cov_reg       <= prt_pkg::COV_NONE;
                        adj_found_reg <= 1'b0;
                        nxt_match_reg <= 1'b0;
                        iss_reg       <= '0;
                        v1_reg        <= 1'b0;
                        v2_reg        <= 1'b0;
                        state_reg     <= ST_SCAN;
                    end
                end

                ST_SCAN:
                begin
                    // Read, form the end address, then compare: one entry per cycle.
                    if (issue)
                    begin
                        iss_reg <= CNT_W'(iss_reg + CNT_W'(1));
                    end
                    v1_reg <= issue;
                    i1_reg <= iss_reg;
                    v2_reg <= v1_reg;
                    i2_reg <= i1_reg;
                    s2_reg <= rd_start_reg;
                    l2_reg <= rd_len_reg;
                    e2_reg <= {1'b0, rd_start_reg} + rd_len_reg;

                    if (v2_reg && (cmp.full || cmp.part))
                    begin
                        cov_reg   <= cmp.full ? prt_pkg::COV_FULL : prt_pkg::COV_PARTIAL;
                        state_reg <= ST_DECIDE;
                    end
                    else if (v2_reg)
                    begin
                        if (!adj_found_reg && (cmp.adj_front || cmp.adj_back))
                        begin
                            adj_found_reg <= 1'b1;
                            adj_k_reg     <= i2_reg;
                            adj_front_reg <= cmp.adj_front;
                            adj_s_reg     <= s2_reg;
                            adj_l_reg     <= l2_reg;
                        end
                        else if (adj_found_reg && (i2_reg == k_plus1))
                        begin
                            nxt_match_reg <= cmp.adj_front;
                            nxt_l_reg     <= l2_reg;
                        end
                    end
                    else if (!issue && !v1_reg)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end

                ST_DECIDE:
                begin
                    priority if (cmd_reg == prt_pkg::CMD_QUERY)
                    begin
                        status_reg <= prt_pkg::STATUS_OK;
                        state_reg  <= ST_RESP;
                    end
                    else if (is_short || (cov_reg != prt_pkg::COV_NONE))
                    begin
                        status_reg <= prt_pkg::STATUS_REFUSED;
                        state_reg  <= ST_RESP;
                    end
                    else if (adj_found_reg)
                    begin
                        status_reg <= prt_pkg::STATUS_OK;
                        state_reg  <= ST_SUM;
                    end
                    else if (table_full)
                    begin
                        status_reg <= prt_pkg::STATUS_FULL;
                        state_reg  <= ST_RESP;
                    end
                    else
                    begin
                        status_reg <= prt_pkg::STATUS_OK;
                        count_reg  <= CNT_W'(count_reg + CNT_W'(1));
                        state_reg  <= ST_RESP;
                    end
                end

                ST_SUM:
                begin
                    sum_reg   <= adj_l_reg + {1'b0, len_reg};
                    state_reg <= ST_SUM_NEXT;
                end

                ST_SUM_NEXT:
                begin
                    if (nxt_match_reg)
                    begin
                        sum_reg <= sum_reg + nxt_l_reg;
                    end
                    state_reg <= ST_WRITE;
                end

                ST_WRITE:
                begin
                    if (nxt_match_reg)
                    begin
                        // The following entry has been absorbed; close the gap.
                        iss_reg   <= CNT_W'(adj_k_reg + CNT_W'(2));
                        v1_reg    <= 1'b0;
                        state_reg <= ST_SHIFT;
                    end
                    else
                    begin
                        state_reg <= ST_RESP;
                    end
                end

                ST_SHIFT:
                begin
                    if (issue)
                    begin
                        iss_reg <= CNT_W'(iss_reg + CNT_W'(1));
                    end
                    v1_reg <= issue;
                    i1_reg <= iss_reg;
                    if (!issue && !v1_reg)
                    begin
                        count_reg <= CNT_W'(count_reg - CNT_W'(1));
                        state_reg <= ST_RESP;
                    end
                end

                ST_RESP:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg  <= 1'b1;
                        m_cov_reg    <= cov_reg;
                        m_status_reg <= status_reg;
                        state_reg    <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0000, m_status_reg, m_cov_reg};

    `PRT_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH),
        "entry count exceeds table depth")

    `PRT_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "block ready again directly after accepting a transaction")

    `PRT_ASSERT_NOW(a_full_has_no_cover,
        m_valid_reg && (m_status_reg == prt_pkg::STATUS_FULL),
        m_cov_reg == prt_pkg::COV_NONE,
        "table full reported for a span that is already covered")

    `PRT_ASSERT_NOW(a_count_step, !$stable(count_reg),
        (count_reg == CNT_W'($past(count_reg) + CNT_W'(1))) ||
        (count_reg == CNT_W'($past(count_reg) - CNT_W'(1))),
        "entry count moved by more than one")

endmodule

>>> test/range_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Protected range table checker
// Watches both streams and keeps its own copy of the region table. Each
// request transaction yields a predicted answer. Each result transaction is
// compared, field by field, with the oldest answer still open.
// ----------------------------------------------------------------------------
module range_table_checker
#(
    parameter int TABLE_DEPTH    = 16,
    parameter int MIN_REGION_LEN = 8
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // start_addr [31:0], span_len [63:32]
    input  logic        s_axis_tuser,   // cmd [0]

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // coverage [1:0], status [3:2], zero [7:4]

    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        logic [1:0] coverage;
        logic [1:0] status;
    } answer_t;

    logic [31:0] region_base [TABLE_DEPTH];
    logic [32:0] region_size [TABLE_DEPTH];
    int          region_count;
    answer_t     open_answers [$];

    // Ends are formed in 34 bits: a 32-bit start plus a 33-bit length.
    function automatic logic [1:0] span_cover(logic [31:0] pos, logic [32:0] nbytes);
        logic [33:0] span_end;
        logic [33:0] rgn_end;
        int          k;
        span_end = {2'b00, pos} + {1'b0, nbytes};
        for (k = 0; k < region_count; k++)
        begin
            rgn_end = {2'b00, region_base[k]} + {1'b0, region_size[k]};
            if (region_base[k] <= pos && rgn_end >= span_end)
                return prt_pkg::COV_FULL;
            if ((region_base[k] >= pos && {2'b00, region_base[k]} < span_end) ||
                (region_base[k] <= pos && rgn_end > {2'b00, pos}))
                return prt_pkg::COV_PARTIAL;
        end
        return prt_pkg::COV_NONE;
    endfunction

    function automatic logic [1:0] add_region(logic [31:0] pos, logic [32:0] nbytes);
        logic [33:0] new_end;
        logic [33:0] rgn_end;
        int          k;
        int          j;
        new_end = {2'b00, pos} + {1'b0, nbytes};
        for (k = 0; k < region_count; k++)
        begin
            rgn_end = {2'b00, region_base[k]} + {1'b0, region_size[k]};
            if (new_end != {2'b00, region_base[k]} && rgn_end != {2'b00, pos})
                continue;
            if (new_end == {2'b00, region_base[k]})
                region_base[k] = pos;
            region_size[k] = region_size[k] + nbytes;
            // The joined entry swallows the next one when the new end meets it.
            if (k + 1 < region_count && new_end == {2'b00, region_base[k + 1]})
            begin
                region_size[k] = region_size[k] + region_size[k + 1];
                for (j = k + 1; j + 1 < region_count; j++)
                begin
                    region_base[j] = region_base[j + 1];
                    region_size[j] = region_size[j + 1];
                end
                region_count--;
            end
            return prt_pkg::STATUS_OK;
        end
        if (region_count >= TABLE_DEPTH)
            return prt_pkg::STATUS_FULL;
        region_base[region_count] = pos;
        region_size[region_count] = nbytes;
        region_count++;
        return prt_pkg::STATUS_OK;
    endfunction

    function automatic answer_t answer_for(logic cmd, logic [31:0] pos, logic [31:0] nbytes);
        answer_t ans;
        ans.coverage = span_cover(pos, (nbytes == 32'd0) ? 33'd1 : {1'b0, nbytes});
        ans.status   = prt_pkg::STATUS_OK;
        if (cmd == prt_pkg::CMD_PROTECT)
        begin
            if (nbytes < MIN_REGION_LEN || ans.coverage != prt_pkg::COV_NONE)
                ans.status = prt_pkg::STATUS_REFUSED;
            else
                ans.status = add_region(pos, {1'b0, nbytes});
        end
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            open_answers.delete();
            region_count = 0;
            mismatches   = 0;
            outstanding  = 0;
        end
        else
        begin
            // A result never belongs to a request taken at the same edge.
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (open_answers.size() == 0)
                begin
                    $display("%0t: result transaction with no request open, actual %h",
                             $time, m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = open_answers.pop_front();
                    if (m_axis_tdata[1:0] !== want.coverage)
                    begin
                        $display("%0t: coverage mismatch, expected %0d, actual %0d",
                                 $time, want.coverage, m_axis_tdata[1:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[3:2] !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, m_axis_tdata[3:2]);
                        mismatches++;
                    end
                    if (m_axis_tdata[7:4] !== 4'd0)
                    begin
                        $display("%0t: padding mismatch, expected 0, actual %h",
                                 $time, m_axis_tdata[7:4]);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                open_answers.push_back(answer_for(s_axis_tuser, s_axis_tdata[31:0],
                                                  s_axis_tdata[63:32]));
            outstanding = open_answers.size();
        end
    end

endmodule

>>> test/tb_protected_range_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Protected range table testbench
// Drives a directed run through the edge cases of the table (short and
// covered regions, joins at either end, merging, a full table, 33-bit
// lengths) and then random requests built around known region boundaries,
// with random gaps on both streams and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module tb_protected_range_table;

    localparam int TABLE_DEPTH     = 16;
    localparam int MIN_REGION_LEN  = 8;
    localparam int RANDOM_ITEMS    = 2000;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int HOLD_OFF_AT     = 1200;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int CALM_FIRST      = 600;
    localparam int CALM_LAST       = 900;
    localparam int MAX_ANCHORS     = 48;
    localparam int TAIL_CYCLES     = 60;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;

    int          mismatches;
    int          outstanding;
    int          sent_count;
    logic        calm;
    logic [31:0] anchor_addrs [$];
    logic [31:0] frontier;

    assign calm = (sent_count >= CALM_FIRST && sent_count < CALM_LAST);

    protected_range_table
    #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .MIN_REGION_LEN (MIN_REGION_LEN)
    )
    dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    range_table_checker
    #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .MIN_REGION_LEN (MIN_REGION_LEN)
    )
    u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offers one request and returns once the transaction has taken place.
    // Boundaries of low-address regions are kept so that later requests can
    // aim at them.
    task automatic send_item(input logic cmd, input logic [31:0] addr,
                             input logic [31:0] nbytes);
        while (!calm && $urandom_range(0, 99) < 13)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {nbytes, addr};
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_count++;
        if (cmd == prt_pkg::CMD_PROTECT && nbytes >= MIN_REGION_LEN && !addr[31])
        begin
            anchor_addrs.push_back(addr);
            anchor_addrs.push_back(addr + nbytes);
            if (anchor_addrs.size() > MAX_ANCHORS)
            begin
                void'(anchor_addrs.pop_front());
                void'(anchor_addrs.pop_front());
            end
            if (addr + nbytes > frontier)
                frontier = addr + nbytes;
        end
    endtask

    function automatic logic [31:0] pick_anchor();
        return anchor_addrs[$urandom_range(0, anchor_addrs.size() - 1)];
    endfunction

    initial
    begin
        int          n;
        int          roll;
        int          pair;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] addr;
        logic [31:0] nbytes;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = prt_pkg::CMD_QUERY;
        sent_count    = 0;
        frontier      = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(prt_pkg::CMD_QUERY,   32'h0000_0000, 32'h0000_0000);
        send_item(prt_pkg::CMD_QUERY,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(prt_pkg::CMD_PROTECT, 32'h0000_1000, 32'h0000_0000);
        send_item(prt_pkg::CMD_PROTECT, 32'h0000_1000, MIN_REGION_LEN - 1);
        send_item(prt_pkg::CMD_PROTECT, 32'h0000_1000, 32'h0000_0008);
        send_item(prt_pkg::CMD_PROTECT, 32'h0000_1004, 32'h0000_0008);
        send_item(prt_pkg::CMD_PROTECT, 32'h0000_1008, 32'h0000_0008);
        send_item(prt_pkg::CMD_PROTECT, 32'h0000_0FF8, 32'h0000_0008);
        send_item(prt_pkg::CMD_PROTECT, 32'h0000_1020, 32'h0000_0010);
        // Joins the first region at its end and meets the second one.
        send_item(prt_pkg::CMD_PROTECT, 32'h0000_1010, 32'h0000_0010);
        // A region that runs past the top of the 32-bit space.
        send_item(prt_pkg::CMD_PROTECT, 32'hFFFF_FFF8, 32'hFFFF_FFFF);
        send_item(prt_pkg::CMD_PROTECT, 32'hFFFF_FFF0, 32'h0000_0008);
        send_item(prt_pkg::CMD_QUERY,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Fill the table; the last append is refused as the table is full.
        for (n = 0; n < TABLE_DEPTH - 1; n++)
            send_item(prt_pkg::CMD_PROTECT, 32'h0000_2000 + 32 * n, 32'h0000_0010);
        send_item(prt_pkg::CMD_PROTECT, 32'h0000_2010, 32'h0000_0010);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            roll   = $urandom_range(0, 99);
            a      = pick_anchor();
            b      = pick_anchor();
            nbytes = 8 * $urandom_range(1, 8);
            if (roll < 30)
            begin
                addr = a + $urandom_range(0, 16) - 8;
                case ($urandom_range(0, 3))
                    0: nbytes = $urandom_range(0, 1);
                    1: nbytes = $urandom_range(2, 24);
                    2: nbytes = (b > addr) ? b - addr : nbytes;
                    default: ;
                endcase
                send_item(prt_pkg::CMD_QUERY, addr, nbytes);
            end
            else if (roll < 45)
                send_item(prt_pkg::CMD_PROTECT, a, nbytes);
            else if (roll < 54)
                send_item(prt_pkg::CMD_PROTECT, a - nbytes, nbytes);
            else if (roll < 68)
            begin
                // Fill the gap between one region's end and the next region's start.
                pair = $urandom_range(0, anchor_addrs.size() / 2 - 2);
                a    = anchor_addrs[2 * pair + 1];
                b    = anchor_addrs[2 * pair + 2];
                if (b > a && b - a <= 4096)
                    send_item(prt_pkg::CMD_PROTECT, a, b - a);
                else
                    send_item(prt_pkg::CMD_PROTECT, a, nbytes);
            end
            else if (roll < 80)
                send_item(prt_pkg::CMD_PROTECT, frontier + 8 * $urandom_range(1, 4), nbytes);
            else if (roll < 88)
                send_item(prt_pkg::CMD_PROTECT, a + $urandom_range(0, 8),
                          $urandom_range(0, MIN_REGION_LEN - 1));
            else
                send_item(prt_pkg::CMD_QUERY, $urandom(),
                          ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom());
        end
        s_axis_tvalid <= 1'b0;
        // Let the checker record the last request before looking at the open count.
        @(posedge clk);

        while (outstanding != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Result side: random back-pressure, one long hold-off while requests
    // keep coming, and a calm stretch with no gaps at all.
    initial
    begin
        int held;
        bit hold_done;

        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!hold_done && sent_count >= HOLD_OFF_AT)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                for (held = 0; held < HOLD_OFF_CYCLES; held++)
                    @(posedge clk);
            end
            else
            begin
                m_axis_tready <= calm || ($urandom_range(0, 99) >= 13);
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int cycles;

        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

endmodule
